/* design/iosr_pkg.sv */
// Shared types and constants for the I/O interrupt and serial register page.
// Used by iosr_hram, io_interrupt_serial_registers and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package iosr_pkg;

    // Operation codes carried by an input beat.
    typedef enum logic [2:0] {
        OP_READ         = 3'd0,
        OP_WRITE        = 3'd1,
        OP_SERIAL_TICK  = 3'd2,
        OP_IRQ_RAISE    = 3'd3,
        OP_IRQ_CLEAR    = 3'd4,
        OP_SPEED_TOGGLE = 3'd5
    } opcode_t;

    // Configuration register indexes.
    localparam logic CFG_COLOR_HW   = 1'b0;
    localparam logic CFG_COLOR_MODE = 1'b1;

    // Register offsets within the I/O page.
    localparam logic [7:0] ADDR_SERIAL_DATA = 8'h01;
    localparam logic [7:0] ADDR_SERIAL_CTRL = 8'h02;
    localparam logic [7:0] ADDR_IRQ_FLAGS   = 8'h0F;
    localparam logic [7:0] ADDR_EXT_BASE    = 8'h4C;
    localparam logic [7:0] ADDR_SPEED       = 8'h4D;
    localparam logic [7:0] ADDR_BOOT_OFF    = 8'h50;
    localparam logic [7:0] ADDR_INFRARED    = 8'h56;
    localparam logic [7:0] ADDR_RAM_BANK    = 8'h70;
    localparam logic [7:0] ADDR_SCRATCH0    = 8'h72;
    localparam logic [7:0] ADDR_SCRATCH1    = 8'h73;
    localparam logic [7:0] ADDR_SCRATCH2    = 8'h74;
    localparam logic [7:0] ADDR_SCRATCH3    = 8'h75;
    localparam logic [7:0] ADDR_HRAM_BASE   = 8'h80;
    localparam logic [7:0] ADDR_IRQ_ENABLE  = 8'hFF;

    // High RAM geometry.
    localparam int HIGH_RAM_BYTES = 128;
    localparam int HRAM_AW        = $clog2(HIGH_RAM_BYTES);

    // Fixed values: the unmapped byte, the serial bit count and the serial interrupt bit.
    localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;
    localparam logic [3:0] SERIAL_BITS   = 4'd8;
    localparam int         IRQ_SERIAL    = 3;

    // Control of the high RAM for one accepted beat.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [HRAM_AW-1:0] addr;
    } hram_ctrl_t;

endpackage

/* design/iosr_hram.sv */
// High RAM of the I/O page: one write or one read per cycle, registered read data.
// Depends on iosr_pkg.
`timescale 1ns / 1ps

module iosr_hram (
    input  logic                clk,
    input  iosr_pkg::hram_ctrl_t ctrl,
    input  logic [7:0]          wdata,
    output logic [7:0]          rdata
);
    import iosr_pkg::*;

    logic [7:0] mem [HIGH_RAM_BYTES];
    logic [7:0] rdata_reg;

    // Write port; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.addr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[ctrl.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/io_interrupt_serial_registers.sv */
// Top level of the I/O interrupt, serial and system register page.
// Depends on iosr_pkg and iosr_hram.
`timescale 1ns / 1ps

// Channel   Handshake              Beat contents
// in        in_valid / in_ready    opcode, reg_offset, write_data, irq_mask
// out       out_valid / out_ready  read_data, pending_irq, high_speed, ram_bank, boot_rom_off
// cfg       cfg_write              cfg_index, cfg_data
//
// Every input beat gives one output beat: on acceptance it enters the operation
// register (high RAM read), then moves on into the result register.
// One beat per cycle is sustained while the output is not stalled; the register
// state is updated as a beat moves from the operation register into the result register.
// A stalled output holds its beat while the operation register still takes one more.
// Reset clears control and register state but sets the bank to one; high RAM is not cleared.

module io_interrupt_serial_registers (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic [4:0] irq_mask,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic [4:0] pending_irq,
    output logic       high_speed,
    output logic [2:0] ram_bank,
    output logic       boot_rom_off
);
    import iosr_pkg::*;

    // Configuration.
    logic color_hw_reg;
    logic color_mode_reg;

    // Operation register.
    logic       op_valid_reg;
    logic [2:0] op_code_reg;
    logic [7:0] op_addr_reg;
    logic [7:0] op_data_reg;
    logic [4:0] op_mask_reg;

    // Architectural register state.
    logic [7:0] irq_enable_reg,  irq_enable_next;
    logic [4:0] irq_flags_reg,   irq_flags_next;
    logic [7:0] serial_data_reg, serial_data_next;
    logic       sc_start_reg,    sc_start_next;
    logic       sc_fast_reg,     sc_fast_next;
    logic       sc_clock_reg,    sc_clock_next;
    logic [3:0] bits_left_reg,   bits_left_next;
    logic       speed_fast_reg,  speed_fast_next;
    logic       speed_req_reg,   speed_req_next;
    logic [2:0] bank_reg,        bank_next;
    logic       boot_off_reg,    boot_off_next;
    logic [2:0] infrared_reg,    infrared_next;
    logic [7:0] scratch0_reg,    scratch0_next;
    logic [7:0] scratch1_reg,    scratch1_next;
    logic [7:0] scratch2_reg,    scratch2_next;
    logic [2:0] scratch3_reg,    scratch3_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] read_data_reg,   read_data_next;
    logic [4:0] pending_reg,     pending_next;
    logic [2:0] ram_bank_reg,    ram_bank_next;

    logic       in_fire;
    logic       op_fire;
    logic [7:0] hram_rdata;
    logic [4:0] irq_active;
    logic [3:0] bits_left_dec;
    hram_ctrl_t hram_ctrl;

    // Handshake: the operation register moves on when the result register is free.
    assign op_fire  = op_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !op_valid_reg || op_fire;
    assign in_fire  = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_hw_reg   <= 1'b0;
            color_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLOR_HW:   color_hw_reg   <= cfg_data;
                CFG_COLOR_MODE: color_mode_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // High RAM is touched only at acceptance, so accesses keep beat order.
    always_comb
    begin
        hram_ctrl.addr  = reg_offset[HRAM_AW-1:0];
        hram_ctrl.wr_en = in_fire && (opcode == OP_WRITE) && (reg_offset >= ADDR_HRAM_BASE)
                          && (reg_offset != ADDR_IRQ_ENABLE);
        hram_ctrl.rd_en = in_fire && (opcode == OP_READ);
    end

    iosr_hram u_hram (
        .clk   (clk),
        .ctrl  (hram_ctrl),
        .wdata (write_data),
        .rdata (hram_rdata)
    );

    // Operation register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            op_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_code_reg <= opcode;
            op_addr_reg <= reg_offset;
            op_data_reg <= write_data;
            op_mask_reg <= irq_mask;
        end
    end

    assign bits_left_dec = bits_left_reg - 4'd1;

    // Next register state for the beat in the operation register.
    always_comb
    begin
        irq_enable_next  = irq_enable_reg;
        irq_flags_next   = irq_flags_reg;
        serial_data_next = serial_data_reg;
        sc_start_next    = sc_start_reg;
        sc_fast_next     = sc_fast_reg;
        sc_clock_next    = sc_clock_reg;
        bits_left_next   = bits_left_reg;
        speed_fast_next  = speed_fast_reg;
        speed_req_next   = speed_req_reg;
        bank_next        = bank_reg;
        boot_off_next    = boot_off_reg;
        infrared_next    = infrared_reg;
        scratch0_next    = scratch0_reg;
        scratch1_next    = scratch1_reg;
        scratch2_next    = scratch2_reg;
        scratch3_next    = scratch3_reg;

        unique case (opcode_t'(op_code_reg))
            OP_WRITE:
            begin
                if (op_addr_reg == ADDR_IRQ_ENABLE)
                begin
                    irq_enable_next = op_data_reg;
                end
                else if (op_addr_reg >= ADDR_HRAM_BASE)
                begin
                    // High RAM write was done at acceptance.
                end
                else if (op_addr_reg >= ADDR_EXT_BASE)
                begin
                    if (op_addr_reg == ADDR_BOOT_OFF)
                    begin
                        if (op_data_reg[0])
                        begin
                            boot_off_next = 1'b1;
                        end
                    end
                    else if (color_hw_reg)
                    begin
                        case (op_addr_reg)
                            ADDR_SPEED:
                            begin
                                if (color_mode_reg)
                                begin
                                    speed_req_next = op_data_reg[0];
                                end
                            end
                            ADDR_INFRARED:
                            begin
                                if (color_mode_reg)
                                begin
                                    infrared_next = {op_data_reg[7:6], op_data_reg[0]};
                                end
                            end
                            ADDR_RAM_BANK:
                            begin
                                if (color_mode_reg)
                                begin
                                    bank_next = op_data_reg[2:0];
                                end
                            end
                            ADDR_SCRATCH0: scratch0_next = op_data_reg;
                            ADDR_SCRATCH1: scratch1_next = op_data_reg;
                            ADDR_SCRATCH2:
                            begin
                                if (color_mode_reg)
                                begin
                                    scratch2_next = op_data_reg;
                                end
                            end
                            ADDR_SCRATCH3: scratch3_next = op_data_reg[6:4];
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    case (op_addr_reg)
                        ADDR_SERIAL_DATA: serial_data_next = op_data_reg;
                        ADDR_SERIAL_CTRL:
                        begin
                            sc_start_next  = op_data_reg[7];
                            sc_fast_next   = op_data_reg[1] && color_hw_reg;
                            sc_clock_next  = op_data_reg[0];
                            bits_left_next = (op_data_reg[7] && op_data_reg[0]) ?
                                             SERIAL_BITS : 4'd0;
                        end
                        ADDR_IRQ_FLAGS: irq_flags_next = op_data_reg[4:0];
                        default: ;
                    endcase
                end
            end
            OP_SERIAL_TICK:
            begin
                // Shift in a one; the last bit ends the transfer and flags it.
                if (bits_left_reg != 4'd0)
                begin
                    serial_data_next = {serial_data_reg[6:0], 1'b1};
                    bits_left_next   = bits_left_dec;
                    if (bits_left_dec == 4'd0)
                    begin
                        sc_start_next              = 1'b0;
                        irq_flags_next[IRQ_SERIAL] = 1'b1;
                    end
                end
            end
            OP_IRQ_RAISE: irq_flags_next = irq_flags_reg | op_mask_reg;
            OP_IRQ_CLEAR: irq_flags_next = irq_flags_reg & ~op_mask_reg;
            OP_SPEED_TOGGLE:
            begin
                speed_req_next  = 1'b0;
                speed_fast_next = !speed_fast_reg;
            end
            default: ;
        endcase
    end

    // Read byte for the beat in the operation register, from the state before it.
    always_comb
    begin
        read_data_next = 8'h00;
        if (op_code_reg == OP_READ)
        begin
            read_data_next = BYTE_UNMAPPED;
            if (op_addr_reg == ADDR_IRQ_ENABLE)
            begin
                read_data_next = irq_enable_reg;
            end
            else if (op_addr_reg >= ADDR_HRAM_BASE)
            begin
                read_data_next = hram_rdata;
            end
            else if (op_addr_reg >= ADDR_EXT_BASE)
            begin
                if (color_hw_reg)
                begin
                    case (op_addr_reg)
                        ADDR_SPEED:
                        begin
                            if (color_mode_reg)
                            begin
                                read_data_next = {speed_fast_reg, 6'h3F, speed_req_reg};
                            end
                        end
                        ADDR_INFRARED:
                            read_data_next = {infrared_reg[2:1], 5'h1F, infrared_reg[0]};
                        ADDR_RAM_BANK:
                        begin
                            if (color_mode_reg)
                            begin
                                read_data_next = {5'h1F, bank_reg};
                            end
                        end
                        ADDR_SCRATCH0: read_data_next = scratch0_reg;
                        ADDR_SCRATCH1: read_data_next = scratch1_reg;
                        ADDR_SCRATCH2:
                        begin
                            if (color_mode_reg)
                            begin
                                read_data_next = scratch2_reg;
                            end
                        end
                        ADDR_SCRATCH3: read_data_next = {1'b1, scratch3_reg, 4'hF};
                        default: ;
                    endcase
                end
            end
            else
            begin
                case (op_addr_reg)
                    ADDR_SERIAL_DATA: read_data_next = serial_data_reg;
                    ADDR_SERIAL_CTRL:
                        read_data_next = {sc_start_reg, 5'h1F, sc_fast_reg || !color_hw_reg,
                                          sc_clock_reg};
                    ADDR_IRQ_FLAGS: read_data_next = {3'b111, irq_flags_reg};
                    default: ;
                endcase
            end
        end
    end

    // Pending interrupt: lowest set bit of the enabled flags, after the update.
    assign irq_active   = irq_flags_next & irq_enable_next[4:0];
    assign pending_next = irq_active & (~irq_active + 5'd1);

    // Effective bank: bank zero selects bank one, and only color mode banks.
    assign ram_bank_next = (color_mode_reg && (bank_next != 3'd0)) ? bank_next : 3'd1;

    // Register state commits as the beat leaves the operation register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_enable_reg  <= 8'h00;
            irq_flags_reg   <= 5'h00;
            serial_data_reg <= 8'h00;
            sc_start_reg    <= 1'b0;
            sc_fast_reg     <= 1'b0;
            sc_clock_reg    <= 1'b0;
            bits_left_reg   <= 4'd0;
            speed_fast_reg  <= 1'b0;
            speed_req_reg   <= 1'b0;
            bank_reg        <= 3'd1;
            boot_off_reg    <= 1'b0;
            infrared_reg    <= 3'd0;
            scratch0_reg    <= 8'h00;
            scratch1_reg    <= 8'h00;
            scratch2_reg    <= 8'h00;
            scratch3_reg    <= 3'd0;
        end
        else if (op_fire)
        begin
            irq_enable_reg  <= irq_enable_next;
            irq_flags_reg   <= irq_flags_next;
            serial_data_reg <= serial_data_next;
            sc_start_reg    <= sc_start_next;
            sc_fast_reg     <= sc_fast_next;
            sc_clock_reg    <= sc_clock_next;
            bits_left_reg   <= bits_left_next;
            speed_fast_reg  <= speed_fast_next;
            speed_req_reg   <= speed_req_next;
            bank_reg        <= bank_next;
            boot_off_reg    <= boot_off_next;
            infrared_reg    <= infrared_next;
            scratch0_reg    <= scratch0_next;
            scratch1_reg    <= scratch1_next;
            scratch2_reg    <= scratch2_next;
            scratch3_reg    <= scratch3_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_fire)
        begin
            read_data_reg <= read_data_next;
            pending_reg   <= pending_next;
            ram_bank_reg  <= ram_bank_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign pending_irq  = pending_reg;
    assign high_speed   = speed_fast_reg;
    assign ram_bank     = ram_bank_reg;
    assign boot_rom_off = boot_off_reg;

endmodule

/* tb/io_interrupt_serial_registers_tb.sv */
// Self-checking testbench for the I/O interrupt, serial and system register page.
// Depends on iosr_pkg and io_interrupt_serial_registers, which in turn uses iosr_hram.
`timescale 1ns / 1ps

module io_interrupt_serial_registers_tb;
    import iosr_pkg::*;

    // Opcodes that the block must accept and ignore.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 178;
    localparam int PHASE_COUNT      = 9;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_STALL       = 64;

    // Offsets that random traffic favors, eight bits per entry.
    localparam logic [8*16-1:0] HOT_OFFSETS = {
        8'h00, ADDR_SERIAL_DATA, ADDR_SERIAL_CTRL, ADDR_IRQ_FLAGS,
        ADDR_EXT_BASE, ADDR_SPEED, ADDR_BOOT_OFF, ADDR_INFRARED,
        ADDR_RAM_BANK, ADDR_SCRATCH0, ADDR_SCRATCH1, ADDR_SCRATCH2,
        ADDR_SCRATCH3, 8'h7F, ADDR_HRAM_BASE, ADDR_IRQ_ENABLE
    };

    // Configuration used in each phase: color hardware, then color mode.
    localparam logic [2*PHASE_COUNT-1:0] PHASE_CFG = {
        2'b00, 2'b11, 2'b10, 2'b01, 2'b11, 2'b00, 2'b10, 2'b11, 2'b01
    };

    typedef struct {
        logic [2:0] op;
        logic [7:0] offs;
        logic [7:0] data;
        logic [4:0] mask;
    } io_access_t;

    typedef struct {
        logic [7:0] rdata;
        logic [4:0] pend;
        logic       speed;
        logic [2:0] bank;
        logic       boot;
    } io_result_t;

    // Block ports.
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_write    = 1'b0;
    logic       cfg_index    = 1'b0;
    logic       cfg_data     = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [2:0] opcode       = 3'd0;
    logic [7:0] reg_offset   = 8'd0;
    logic [7:0] write_data   = 8'd0;
    logic [4:0] irq_mask     = 5'd0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] read_data;
    logic [4:0] pending_irq;
    logic       high_speed;
    logic [2:0] ram_bank;
    logic       boot_rom_off;

    // Predicted register state of the page.
    logic       color_hw     = 1'b0;
    logic       color_mode   = 1'b0;
    logic [7:0] irq_en       = 8'd0;
    logic [4:0] irq_fl       = 5'd0;
    logic [7:0] sio_data     = 8'd0;
    logic [7:0] sio_ctrl     = 8'd0;
    logic [3:0] sio_bits     = 4'd0;
    logic       dbl_speed    = 1'b0;
    logic       speed_armed  = 1'b0;
    logic [2:0] wram_bank    = 3'd1;
    logic       boot_off     = 1'b0;
    logic [7:0] ir_reg       = 8'd0;
    logic [7:0] scratch [4]  = '{8'd0, 8'd0, 8'd0, 8'd0};
    logic [7:0] hram [HIGH_RAM_BYTES];

    // High RAM bytes that queued traffic has written, so reads stay defined.
    logic [HIGH_RAM_BYTES-1:0] hram_touched = '0;

    io_access_t pending_accesses[$];
    io_result_t predicted_results[$];

    int feed_idle_pct  = 0;
    int drain_idle_pct = 0;
    int queued_items   = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int stall_left     = 0;
    int cycle_count    = 0;

    io_interrupt_serial_registers DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .reg_offset   (reg_offset),
        .write_data   (write_data),
        .irq_mask     (irq_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .pending_irq  (pending_irq),
        .high_speed   (high_speed),
        .ram_bank     (ram_bank),
        .boot_rom_off (boot_rom_off)
    );

    always #4 clk = ~clk;

    // Apply one accepted beat to the predicted page and record its result.
    task automatic model_io_access(input logic [2:0] op, input logic [7:0] a,
                                   input logic [7:0] v, input logic [4:0] m);
        io_result_t res;
        logic [4:0] active;
        res = '{8'd0, 5'd0, 1'b0, 3'd1, 1'b0};
        case (op)
            OP_READ:
            begin
                if (a == ADDR_IRQ_ENABLE)
                    res.rdata = irq_en;
                else if (a >= ADDR_HRAM_BASE)
                    res.rdata = hram[a[6:0]];
                else if (a >= ADDR_EXT_BASE)
                begin
                    res.rdata = BYTE_UNMAPPED;
                    if (color_hw)
                    begin
                        case (a)
                            ADDR_SPEED:
                                if (color_mode)
                                    res.rdata = {dbl_speed, 6'h3F, speed_armed};
                            ADDR_INFRARED: res.rdata = ir_reg | 8'h3E;
                            ADDR_RAM_BANK:
                                if (color_mode)
                                    res.rdata = {5'h1F, wram_bank};
                            ADDR_SCRATCH0: res.rdata = scratch[0];
                            ADDR_SCRATCH1: res.rdata = scratch[1];
                            ADDR_SCRATCH2:
                                if (color_mode)
                                    res.rdata = scratch[2];
                            ADDR_SCRATCH3: res.rdata = scratch[3] | 8'h8F;
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    case (a)
                        ADDR_SERIAL_DATA: res.rdata = sio_data;
                        ADDR_SERIAL_CTRL: res.rdata = sio_ctrl | (color_hw ? 8'h7C : 8'h7E);
                        ADDR_IRQ_FLAGS:   res.rdata = {3'b111, irq_fl};
                        default:          res.rdata = BYTE_UNMAPPED;
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (a == ADDR_IRQ_ENABLE)
                    irq_en = v;
                else if (a >= ADDR_HRAM_BASE)
                    hram[a[6:0]] = v;
                else if (a == ADDR_BOOT_OFF)
                begin
                    // The boot latch works on any hardware and never clears.
                    if (v[0])
                        boot_off = 1'b1;
                end
                else if (a >= ADDR_EXT_BASE)
                begin
                    if (color_hw)
                    begin
                        case (a)
                            ADDR_SPEED:
                                if (color_mode)
                                    speed_armed = v[0];
                            ADDR_INFRARED:
                                if (color_mode)
                                    ir_reg = v & 8'hC1;
                            ADDR_RAM_BANK:
                                if (color_mode)
                                    wram_bank = v[2:0];
                            ADDR_SCRATCH0: scratch[0] = v;
                            ADDR_SCRATCH1: scratch[1] = v;
                            ADDR_SCRATCH2:
                                if (color_mode)
                                    scratch[2] = v;
                            ADDR_SCRATCH3: scratch[3] = v;
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    case (a)
                        ADDR_SERIAL_DATA: sio_data = v;
                        ADDR_SERIAL_CTRL:
                        begin
                            // Start bit plus internal clock arms an 8-bit transfer.
                            sio_ctrl = v & (color_hw ? 8'h83 : 8'h81);
                            sio_bits = (sio_ctrl[7] && sio_ctrl[0]) ? SERIAL_BITS : 4'd0;
                        end
                        ADDR_IRQ_FLAGS: irq_fl = v[4:0];
                        default: ;
                    endcase
                end
            end
            OP_SERIAL_TICK:
            begin
                if (sio_bits != 4'd0)
                begin
                    sio_data = {sio_data[6:0], 1'b1};
                    sio_bits = sio_bits - 4'd1;
                    if (sio_bits == 4'd0)
                    begin
                        sio_ctrl[7]        = 1'b0;
                        irq_fl[IRQ_SERIAL] = 1'b1;
                    end
                end
            end
            OP_IRQ_RAISE:    irq_fl = irq_fl | m;
            OP_IRQ_CLEAR:    irq_fl = irq_fl & ~m;
            OP_SPEED_TOGGLE:
            begin
                speed_armed = 1'b0;
                dbl_speed   = ~dbl_speed;
            end
            default: ;
        endcase

        // Lowest pending source wins.
        active    = irq_fl & irq_en[4:0];
        res.pend  = active & (~active + 5'd1);
        res.speed = dbl_speed;
        res.bank  = color_mode ? ((wram_bank == 3'd0) ? 3'd1 : wram_bank) : 3'd1;
        res.boot  = boot_off;
        predicted_results.push_back(res);
    endtask

    // Queue one beat for the driver, tracking which high RAM bytes become defined.
    task automatic queue_access(input logic [2:0] op, input logic [7:0] offs,
                                input logic [7:0] data, input logic [4:0] mask);
        io_access_t acc;
        acc = '{op, offs, data, mask};
        if (op == OP_WRITE && offs >= ADDR_HRAM_BASE && offs != ADDR_IRQ_ENABLE)
            hram_touched[offs[6:0]] = 1'b1;
        pending_accesses.push_back(acc);
        queued_items++;
    endtask

    // Configuration writes happen only while the page is idle.
    task automatic write_cfg(input logic idx, input logic val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_COLOR_HW)
            color_hw = val;
        else
            color_mode = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Compare one received beat with the oldest prediction.
    task automatic check_io_result();
        io_result_t want;
        results_seen++;
        if (predicted_results.size() == 0)
        begin
            $display("%0t: result beat with nothing predicted, read_data %h",
                     $time, read_data);
            mismatch_count++;
        end
        else
        begin
            want = predicted_results.pop_front();
            if (read_data !== want.rdata)
            begin
                $display("%0t: read_data expected %h actual %h", $time, want.rdata, read_data);
                mismatch_count++;
            end
            if (pending_irq !== want.pend)
            begin
                $display("%0t: pending_irq expected %h actual %h",
                         $time, want.pend, pending_irq);
                mismatch_count++;
            end
            if (high_speed !== want.speed)
            begin
                $display("%0t: high_speed expected %b actual %b",
                         $time, want.speed, high_speed);
                mismatch_count++;
            end
            if (ram_bank !== want.bank)
            begin
                $display("%0t: ram_bank expected %0d actual %0d", $time, want.bank, ram_bank);
                mismatch_count++;
            end
            if (boot_rom_off !== want.boot)
            begin
                $display("%0t: boot_rom_off expected %b actual %b",
                         $time, want.boot, boot_rom_off);
                mismatch_count++;
            end
        end
    endtask

    // Input driver: predicts each accepted beat, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        io_access_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                model_io_access(opcode, reg_offset, write_data, irq_mask);
            if (!in_valid || in_ready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= feed_idle_pct)
                begin
                    nxt = pending_accesses.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= nxt.op;
                    reg_offset <= nxt.offs;
                    write_data <= nxt.data;
                    irq_mask   <= nxt.mask;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks result beats and applies back pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_io_result();
            if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (out_valid && out_ready && (results_seen % 500) == 120)
            begin
                // Hold off long enough for the pipeline to fill and block its input.
                out_ready  <= 1'b0;
                stall_left <= LONG_STALL;
            end
            else
                out_ready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: one phase per PHASE_CFG entry; configuration settings repeat across phases.
    initial
    begin : stimulus
        int         phase;
        int         start_count;
        int         pick;
        int         n_ticks;
        logic [2:0] op;
        logic [7:0] offs;
        logic [7:0] data;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_cfg(CFG_COLOR_HW, PHASE_CFG[2*(PHASE_COUNT-1-phase)+1]);
            write_cfg(CFG_COLOR_MODE, PHASE_CFG[2*(PHASE_COUNT-1-phase)]);

            // Receiver busy first, then sender busy, then no idling at all.
            if (phase < 3)
            begin
                feed_idle_pct  <= 24;
                drain_idle_pct <= 54;
            end
            else if (phase < 6)
            begin
                feed_idle_pct  <= 54;
                drain_idle_pct <= 24;
            end
            else
            begin
                feed_idle_pct  <= 0;
                drain_idle_pct <= 0;
            end

            if (phase == 0)
            begin
                // Plain hardware: extra registers are dead except the boot latch.
                queue_access(OP_WRITE, ADDR_SPEED, 8'h01, 5'h00);
                queue_access(OP_READ, ADDR_SPEED, 8'h00, 5'h00);
                queue_access(OP_WRITE, ADDR_BOOT_OFF, 8'hFE, 5'h00);
                queue_access(OP_WRITE, ADDR_BOOT_OFF, 8'h01, 5'h00);
                queue_access(OP_READ, ADDR_BOOT_OFF, 8'h00, 5'h00);
                queue_access(OP_SERIAL_TICK, 8'hFF, 8'hFF, 5'h1F);
                queue_access(OP_SPARE_6, 8'hFF, 8'hFF, 5'h1F);
                queue_access(OP_SPARE_7, 8'h00, 8'h00, 5'h00);
            end
            else if (phase == 1)
            begin
                // Color mode: bank, speed and infrared registers, interrupt extremes, high RAM ends.
                queue_access(OP_WRITE, ADDR_IRQ_ENABLE, 8'hFF, 5'h00);
                queue_access(OP_IRQ_RAISE, 8'h00, 8'h00, 5'h1F);
                queue_access(OP_READ, ADDR_IRQ_FLAGS, 8'h00, 5'h00);
                queue_access(OP_IRQ_CLEAR, 8'h00, 8'h00, 5'h1F);
                queue_access(OP_WRITE, ADDR_RAM_BANK, 8'h00, 5'h00);
                queue_access(OP_READ, ADDR_RAM_BANK, 8'h00, 5'h00);
                queue_access(OP_WRITE, ADDR_SPEED, 8'hFF, 5'h00);
                queue_access(OP_SPEED_TOGGLE, 8'h00, 8'h00, 5'h00);
                queue_access(OP_READ, ADDR_SPEED, 8'h00, 5'h00);
                queue_access(OP_WRITE, ADDR_INFRARED, 8'hFF, 5'h00);
                queue_access(OP_READ, ADDR_INFRARED, 8'h00, 5'h00);
                queue_access(OP_WRITE, ADDR_HRAM_BASE, 8'h00, 5'h00);
                queue_access(OP_WRITE, 8'hFE, 8'hFF, 5'h00);
                queue_access(OP_READ, 8'hFE, 8'h00, 5'h00);
                queue_access(OP_READ, ADDR_IRQ_ENABLE, 8'h00, 5'h00);
                queue_access(OP_READ, ADDR_HRAM_BASE, 8'h00, 5'h00);
                queue_access(OP_WRITE, ADDR_SERIAL_CTRL, 8'h83, 5'h00);
            end

            // Random traffic with occasional complete serial transfers.
            start_count = queued_items;
            while (queued_items - start_count < RANDOM_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                begin
                    queue_access(OP_WRITE, ADDR_SERIAL_DATA, 8'($urandom), 5'($urandom));
                    queue_access(OP_WRITE, ADDR_IRQ_ENABLE, 8'($urandom), 5'($urandom));
                    queue_access(OP_WRITE, ADDR_SERIAL_CTRL, 8'($urandom) | 8'h81,
                                 5'($urandom));
                    n_ticks = 8 + int'($urandom_range(2));
                    repeat (n_ticks)
                    begin
                        if ($urandom_range(3) == 0)
                            queue_access(OP_READ, ADDR_SERIAL_DATA, 8'($urandom),
                                         5'($urandom));
                        queue_access(OP_SERIAL_TICK, 8'($urandom), 8'($urandom),
                                     5'($urandom));
                    end
                    queue_access(OP_READ, ADDR_IRQ_FLAGS, 8'($urandom), 5'($urandom));
                    queue_access(OP_READ, ADDR_SERIAL_CTRL, 8'($urandom), 5'($urandom));
                    if ($urandom_range(1) == 1)
                        queue_access(OP_IRQ_CLEAR, 8'($urandom), 8'($urandom),
                                     5'h08 | 5'($urandom));
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                        op = OP_READ;
                    else if (pick < 60)
                        op = OP_WRITE;
                    else if (pick < 72)
                        op = OP_SERIAL_TICK;
                    else if (pick < 80)
                        op = OP_IRQ_RAISE;
                    else if (pick < 88)
                        op = OP_IRQ_CLEAR;
                    else if (pick < 92)
                        op = OP_SPEED_TOGGLE;
                    else if (pick < 96)
                        op = OP_SPARE_6;
                    else
                        op = OP_SPARE_7;

                    pick = $urandom_range(9);
                    if (pick < 5)
                        offs = HOT_OFFSETS[8*$urandom_range(15) +: 8];
                    else if (pick < 8)
                        offs = ADDR_HRAM_BASE + 8'($urandom_range(126));
                    else
                        offs = 8'($urandom_range(255));

                    data = 8'($urandom);
                    if (op == OP_WRITE && offs == ADDR_SERIAL_CTRL && $urandom_range(1) == 1)
                        data = data | 8'h81;

                    // Never read a high RAM byte before it has been written.
                    if (op == OP_READ && offs >= ADDR_HRAM_BASE && offs != ADDR_IRQ_ENABLE
                        && !hram_touched[offs[6:0]])
                        op = OP_WRITE;

                    queue_access(op, offs, data, 5'($urandom));
                end
            end

            // Let the phase drain before touching configuration again.
            do
                @(posedge clk);
            while (pending_accesses.size() != 0 || in_valid || predicted_results.size() != 0);
            repeat (4) @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
